[src/polp_pkg.sv]
// shared types, codes and width helpers for the point onto line projector
package polp_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] csr_index_type;

   localparam kind_type KIND_GENERAL    = 2'd0;
   localparam kind_type KIND_HORIZONTAL = 2'd1;

   localparam csr_index_type REG_GRADIENT  = 2'd0;
   localparam csr_index_type REG_INTERCEPT = 2'd1;
   localparam csr_index_type REG_KIND      = 2'd2;

   typedef struct packed {
      logic vertical;
      logic bypass;
   } mode_type;

   // signed width of the two general-case numerators before scaling
   function automatic int sum_bits(int coord_bits, int frac_bits);
      return ((coord_bits > frac_bits) ? 2 * coord_bits : coord_bits + frac_bits) + 2;
   endfunction

   // numerator magnitude, scaled by 2^(frac+1) for the round bit
   function automatic int num_bits(int coord_bits, int frac_bits);
      return sum_bits(coord_bits, frac_bits) + frac_bits + 1;
   endfunction

   function automatic int den_bits(int coord_bits, int frac_bits);
      return ((coord_bits > frac_bits) ? 2 * coord_bits : 2 * frac_bits) + 1;
   endfunction

   // quotient bits kept; anything larger saturates
   function automatic int quo_bits(int coord_bits);
      return coord_bits + 2;
   endfunction

endpackage

[src/polp_if.sv]
// valid/ready channels for points in and projected results out
interface polp_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source(output valid, point_x, point_y, input ready);
   modport sink(input valid, point_x, point_y, output ready);
endinterface

interface polp_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] foot_x;
   logic signed [COORD_BITS-1:0] foot_y;
   logic signed [COORD_BITS-1:0] position_on_line;
   logic                         saturated;

   modport source(output valid, foot_x, foot_y, position_on_line, saturated, input ready);
   modport sink(input valid, foot_x, foot_y, position_on_line, saturated, output ready);
endinterface

[src/polp_front.sv]
// front pipeline: products, numerators, denominator and magnitudes (4 stages)
module polp_front #(
   parameter int  COORD_BITS = 32,
   parameter int  FRAC_BITS  = 16,
   localparam int NUM_BITS   = polp_pkg::num_bits(COORD_BITS, FRAC_BITS),
   localparam int DEN_BITS   = polp_pkg::den_bits(COORD_BITS, FRAC_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] line_gradient,
   input  logic signed [COORD_BITS-1:0] line_intercept,
   input  polp_pkg::kind_type           line_kind,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [NUM_BITS-1:0]          num_x,
   output logic [NUM_BITS-1:0]          num_t,
   output logic [DEN_BITS-1:0]          den,
   output logic                         neg_x,
   output logic                         neg_t,
   output logic signed [COORD_BITS-1:0] px,
   output logic signed [COORD_BITS-1:0] py,
   output logic signed [COORD_BITS-1:0] b,
   output polp_pkg::mode_type           mode
);
   import polp_pkg::*;

   localparam int SW = sum_bits(COORD_BITS, FRAC_BITS);
   localparam int PW = 2 * COORD_BITS + 1;
   localparam int DW = COORD_BITS + 1;

   logic [3:0] v_ff;
   logic [3:0] adv;

   assign adv[3]    = !v_ff[3] || out_ready;
   assign adv[2]    = !v_ff[2] || adv[3];
   assign adv[1]    = !v_ff[1] || adv[2];
   assign adv[0]    = !v_ff[0] || adv[1];
   assign in_ready  = adv[0];
   assign out_valid = v_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1: capture, offset from intercept, line case
   logic signed [COORD_BITS-1:0] px1_ff, py1_ff, b1_ff, m1_ff;
   logic signed [DW-1:0]         d1_ff, d1_in;
   mode_type                     mode1_ff, mode1_in;

   always_comb begin
      d1_in = DW'(point_y) - DW'(line_intercept);
      // the unused kind code falls to vertical
      mode1_in.vertical = !(line_kind == KIND_GENERAL || line_kind == KIND_HORIZONTAL);
      mode1_in.bypass   = (line_kind == KIND_HORIZONTAL) ||
                          (line_kind == KIND_GENERAL && line_gradient == '0);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         px1_ff   <= point_x;
         py1_ff   <= point_y;
         b1_ff    <= line_intercept;
         m1_ff    <= line_gradient;
         d1_ff    <= d1_in;
         mode1_ff <= mode1_in;
      end
   end

   // stage 2: products
   logic signed [PW-1:0]         md2_ff, mp2_ff, mm2_ff;
   logic signed [COORD_BITS-1:0] px2_ff, py2_ff, b2_ff;
   logic signed [DW-1:0]         d2_ff;
   mode_type                     mode2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         md2_ff   <= PW'(m1_ff) * PW'(d1_ff);
         mp2_ff   <= PW'(m1_ff) * PW'(px1_ff);
         mm2_ff   <= PW'(m1_ff) * PW'(m1_ff);
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         b2_ff    <= b1_ff;
         d2_ff    <= d1_ff;
         mode2_ff <= mode1_ff;
      end
   end

   // stage 3: numerators and denominator
   logic signed [SW-1:0]         nx3_ff, nt3_ff, nx3_in, nt3_in;
   logic [DEN_BITS-1:0]          den3_ff, den3_in;
   logic signed [COORD_BITS-1:0] px3_ff, py3_ff, b3_ff;
   mode_type                     mode3_ff;

   always_comb begin
      nx3_in  = (SW'(px2_ff) <<< FRAC_BITS) + SW'(md2_ff);
      nt3_in  = SW'(mp2_ff) - (SW'(d2_ff) <<< FRAC_BITS);
      den3_in = DEN_BITS'(mm2_ff[2*COORD_BITS-1:0]) + (DEN_BITS'(1) << (2 * FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         nx3_ff   <= nx3_in;
         nt3_ff   <= nt3_in;
         den3_ff  <= den3_in;
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         b3_ff    <= b2_ff;
         mode3_ff <= mode2_ff;
      end
   end

   // stage 4: sign and magnitude, scaled for the extra round bit
   logic [SW-1:0]                magx, magt;
   logic [NUM_BITS-1:0]          numx4_ff, numt4_ff;
   logic [DEN_BITS-1:0]          den4_ff;
   logic                         negx4_ff, negt4_ff;
   logic signed [COORD_BITS-1:0] px4_ff, py4_ff, b4_ff;
   mode_type                     mode4_ff;

   always_comb begin
      magx = nx3_ff[SW-1] ? -nx3_ff : nx3_ff;
      magt = nt3_ff[SW-1] ? -nt3_ff : nt3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         numx4_ff <= NUM_BITS'(magx) << (FRAC_BITS + 1);
         numt4_ff <= NUM_BITS'(magt) << (FRAC_BITS + 1);
         negx4_ff <= nx3_ff[SW-1];
         negt4_ff <= nt3_ff[SW-1];
         den4_ff  <= den3_ff;
         px4_ff   <= px3_ff;
         py4_ff   <= py3_ff;
         b4_ff    <= b3_ff;
         mode4_ff <= mode3_ff;
      end
   end

   assign num_x = numx4_ff;
   assign num_t = numt4_ff;
   assign den   = den4_ff;
   assign neg_x = negx4_ff;
   assign neg_t = negt4_ff;
   assign px    = px4_ff;
   assign py    = py4_ff;
   assign b     = b4_ff;
   assign mode  = mode4_ff;

endmodule

[src/polp_div.sv]
// pipelined restoring divider, one quotient bit per stage, two numerators share a divisor
module polp_div #(
   parameter int NUM_BITS  = 99,
   parameter int DEN_BITS  = 65,
   parameter int QUO_BITS  = 34,
   parameter int SIDE_BITS = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NUM_BITS-1:0]  num_x,
   input  logic [NUM_BITS-1:0]  num_t,
   input  logic [DEN_BITS-1:0]  den,
   input  logic [SIDE_BITS-1:0] side_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QUO_BITS-1:0]  quo_x,
   output logic [QUO_BITS-1:0]  quo_t,
   output logic                 over_x,
   output logic                 over_t,
   output logic [SIDE_BITS-1:0] side_out
);
   localparam int RW   = (NUM_BITS > DEN_BITS + QUO_BITS) ? NUM_BITS : DEN_BITS + QUO_BITS;
   localparam int LAST = QUO_BITS;

   logic [LAST:0]          v_ff;
   logic [LAST:0]          adv;
   logic [RW-1:0]          rx_ff   [0:LAST];
   logic [RW-1:0]          rt_ff   [0:LAST];
   logic [DEN_BITS-1:0]    d_ff    [0:LAST];
   logic [QUO_BITS-1:0]    qx_ff   [0:LAST];
   logic [QUO_BITS-1:0]    qt_ff   [0:LAST];
   logic [LAST:0]          ox_ff;
   logic [LAST:0]          ot_ff;
   logic [SIDE_BITS-1:0]   side_ff [0:LAST];

   assign adv[LAST] = !v_ff[LAST] || out_ready;
   for (genvar i = 0; i < LAST; i++) begin : g_ready
      assign adv[i] = !v_ff[i] || adv[i+1];
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int i = 1; i <= LAST; i++) begin
            if (adv[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage 0: quotient too large for the kept bits means saturation
   logic [RW-1:0] top_den;
   logic          ox_in, ot_in;

   always_comb begin
      top_den = RW'(den) << QUO_BITS;
      ox_in   = RW'(num_x) >= top_den;
      ot_in   = RW'(num_t) >= top_den;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rx_ff[0]   <= RW'(num_x);
         rt_ff[0]   <= RW'(num_t);
         d_ff[0]    <= den;
         qx_ff[0]   <= '0;
         qt_ff[0]   <= '0;
         ox_ff[0]   <= ox_in;
         ot_ff[0]   <= ot_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar i = 1; i <= LAST; i++) begin : g_step
      localparam int J = LAST - i;
      logic [RW-1:0]       trial, rx_in, rt_in;
      logic [QUO_BITS-1:0] qx_in, qt_in;

      always_comb begin
         trial = RW'(d_ff[i-1]) << J;
         rx_in = rx_ff[i-1];
         rt_in = rt_ff[i-1];
         qx_in = qx_ff[i-1];
         qt_in = qt_ff[i-1];
         if (rx_ff[i-1] >= trial) begin
            rx_in    = rx_ff[i-1] - trial;
            qx_in[J] = 1'b1;
         end
         if (rt_ff[i-1] >= trial) begin
            rt_in    = rt_ff[i-1] - trial;
            qt_in[J] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            rx_ff[i]   <= rx_in;
            rt_ff[i]   <= rt_in;
            d_ff[i]    <= d_ff[i-1];
            qx_ff[i]   <= qx_in;
            qt_ff[i]   <= qt_in;
            ox_ff[i]   <= ox_ff[i-1];
            ot_ff[i]   <= ot_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign quo_x     = qx_ff[LAST];
   assign quo_t     = qt_ff[LAST];
   assign over_x    = ox_ff[LAST];
   assign over_t    = ot_ff[LAST];
   assign side_out  = side_ff[LAST];

endmodule

[src/polp_back.sv]
// back pipeline: rounding, foot point, clamping and line case select (3 stages)
module polp_back #(
   parameter int COORD_BITS = 32,
   parameter int QUO_BITS   = 34
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [QUO_BITS-1:0]          quo_x,
   input  logic [QUO_BITS-1:0]          quo_t,
   input  logic                         over_x,
   input  logic                         over_t,
   input  logic                         neg_x,
   input  logic                         neg_t,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] b,
   input  polp_pkg::mode_type           mode,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] foot_x,
   output logic signed [COORD_BITS-1:0] foot_y,
   output logic signed [COORD_BITS-1:0] position_on_line,
   output logic                         saturated
);
   import polp_pkg::*;

   localparam int EW = COORD_BITS + 4;
   localparam logic signed [EW-1:0] MAXV = (EW'(1) <<< (COORD_BITS - 1)) - EW'(1);
   localparam logic signed [EW-1:0] MINV = -MAXV - EW'(1);

   logic [2:0] v_ff;
   logic [2:0] adv;

   assign adv[2]    = !v_ff[2] || out_ready;
   assign adv[1]    = !v_ff[1] || adv[2];
   assign adv[0]    = !v_ff[0] || adv[1];
   assign in_ready  = adv[0];
   assign out_valid = v_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   // stage a: drop the round bit, ties go away from zero
   logic [QUO_BITS:0]            sumx, sumt;
   logic [QUO_BITS-1:0]          qmx_ff, qmt_ff, qmx_in, qmt_in;
   logic                         nxa_ff, nta_ff;
   logic signed [COORD_BITS-1:0] pxa_ff, pya_ff, ba_ff;
   mode_type                     modea_ff;

   always_comb begin
      sumx   = {1'b0, quo_x} + (QUO_BITS+1)'(1);
      sumt   = {1'b0, quo_t} + (QUO_BITS+1)'(1);
      qmx_in = over_x ? (QUO_BITS'(1) << (QUO_BITS - 1)) : sumx[QUO_BITS:1];
      qmt_in = over_t ? (QUO_BITS'(1) << (QUO_BITS - 1)) : sumt[QUO_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         qmx_ff   <= qmx_in;
         qmt_ff   <= qmt_in;
         nxa_ff   <= neg_x;
         nta_ff   <= neg_t;
         pxa_ff   <= px;
         pya_ff   <= py;
         ba_ff    <= b;
         modea_ff <= mode;
      end
   end

   // stage b: signed foot coordinates at full width
   logic signed [EW-1:0]         qx_ext, qt_ext, fxb_in, fyb_in, fxb_ff, fyb_ff;
   logic signed [COORD_BITS-1:0] pxb_ff, pyb_ff, bb_ff;
   mode_type                     modeb_ff;

   always_comb begin
      qx_ext = EW'(qmx_ff);
      qt_ext = EW'(qmt_ff);
      fxb_in = nxa_ff ? -qx_ext : qx_ext;
      fyb_in = nta_ff ? EW'(pya_ff) - qt_ext : EW'(pya_ff) + qt_ext;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         fxb_ff   <= fxb_in;
         fyb_ff   <= fyb_in;
         pxb_ff   <= pxa_ff;
         pyb_ff   <= pya_ff;
         bb_ff    <= ba_ff;
         modeb_ff <= modea_ff;
      end
   end

   // stage c: clamp and pick the line case
   logic signed [COORD_BITS-1:0] cx, cy;
   logic                         sx, sy;
   logic signed [COORD_BITS-1:0] fx_in, fy_in, pos_in, fx_ff, fy_ff, pos_ff;
   logic                         sat_in, sat_ff;

   always_comb begin
      sx = 1'b0;
      sy = 1'b0;
      cx = fxb_ff[COORD_BITS-1:0];
      cy = fyb_ff[COORD_BITS-1:0];
      if (fxb_ff > MAXV) begin
         cx = MAXV[COORD_BITS-1:0];
         sx = 1'b1;
      end else if (fxb_ff < MINV) begin
         cx = MINV[COORD_BITS-1:0];
         sx = 1'b1;
      end
      if (fyb_ff > MAXV) begin
         cy = MAXV[COORD_BITS-1:0];
         sy = 1'b1;
      end else if (fyb_ff < MINV) begin
         cy = MINV[COORD_BITS-1:0];
         sy = 1'b1;
      end
      priority if (modeb_ff.vertical) begin
         fx_in  = bb_ff;
         fy_in  = pyb_ff;
         pos_in = pyb_ff;
         sat_in = 1'b0;
      end else if (modeb_ff.bypass) begin
         fx_in  = pxb_ff;
         fy_in  = bb_ff;
         pos_in = pxb_ff;
         sat_in = 1'b0;
      end else begin
         fx_in  = cx;
         fy_in  = cy;
         pos_in = cx;
         sat_in = sx || sy;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         pos_ff <= pos_in;
         sat_ff <= sat_in;
      end
   end

   assign foot_x           = fx_ff;
   assign foot_y           = fy_ff;
   assign position_on_line = pos_ff;
   assign saturated        = sat_ff;

endmodule

[src/point_onto_line_projector_unit.sv]
// Orthogonal projection of a fixed-point point onto a configured line.
// Points arrive on req_in (point_x, point_y, signed Q format with FRAC_BITS
// fraction bits); each transfer yields exactly one transfer on rsp_out with
// the foot point, its position along the line and a saturation flag.
// The line is set through the csr_ port: gradient, intercept and kind
// (general, horizontal, vertical). Write it only while no point is in flight.
// A req_in transfer passes through 4 front stages for products and
// numerators, one range check plus one stage per quotient bit in the shared
// divider, and 3 stages for rounding, clamping and case select.
// Throughput is one point per cycle while rsp_out is ready; every stage
// has its own valid bit, so bubbles close up and req_in stays ready while
// any stage is free. When rsp_out stalls, results hold in place and the
// pipeline fills behind them; nothing is dropped or repeated.
// Reset clears all valid bits and sets a horizontal line through zero.
module point_onto_line_projector_unit #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   polp_req_if.sink                req_in,
   polp_rsp_if.source              rsp_out,
   input  logic                    csr_we,
   input  polp_pkg::csr_index_type csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata
);
   import polp_pkg::*;

   localparam int NUM_BITS  = num_bits(COORD_BITS, FRAC_BITS);
   localparam int DEN_BITS  = den_bits(COORD_BITS, FRAC_BITS);
   localparam int QUO_BITS  = quo_bits(COORD_BITS);
   localparam int SIDE_BITS = 3 * COORD_BITS + $bits(mode_type) + 2;

   logic signed [COORD_BITS-1:0] gradient_ff, intercept_ff;
   kind_type                     kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gradient_ff  <= '0;
         intercept_ff <= '0;
         kind_ff      <= KIND_HORIZONTAL;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GRADIENT:  gradient_ff  <= csr_wdata;
            REG_INTERCEPT: intercept_ff <= csr_wdata;
            REG_KIND:      kind_ff      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic                         f_valid, f_ready;
   logic [NUM_BITS-1:0]          f_num_x, f_num_t;
   logic [DEN_BITS-1:0]          f_den;
   logic                         f_neg_x, f_neg_t;
   logic signed [COORD_BITS-1:0] f_px, f_py, f_b;
   mode_type                     f_mode;

   polp_front #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_in.valid),
      .in_ready      (req_in.ready),
      .point_x       (req_in.point_x),
      .point_y       (req_in.point_y),
      .line_gradient (gradient_ff),
      .line_intercept(intercept_ff),
      .line_kind     (kind_ff),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .num_x         (f_num_x),
      .num_t         (f_num_t),
      .den           (f_den),
      .neg_x         (f_neg_x),
      .neg_t         (f_neg_t),
      .px            (f_px),
      .py            (f_py),
      .b             (f_b),
      .mode          (f_mode)
   );

   logic [SIDE_BITS-1:0] side_in, side_out;
   logic                 d_valid, d_ready;
   logic [QUO_BITS-1:0]  d_quo_x, d_quo_t;
   logic                 d_over_x, d_over_t;

   assign side_in = {f_px, f_py, f_b, f_mode, f_neg_x, f_neg_t};

   polp_div #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (DEN_BITS),
      .QUO_BITS (QUO_BITS),
      .SIDE_BITS(SIDE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .num_x    (f_num_x),
      .num_t    (f_num_t),
      .den      (f_den),
      .side_in  (side_in),
      .out_valid(d_valid),
      .out_ready(d_ready),
      .quo_x    (d_quo_x),
      .quo_t    (d_quo_t),
      .over_x   (d_over_x),
      .over_t   (d_over_t),
      .side_out (side_out)
   );

   logic signed [COORD_BITS-1:0] d_px, d_py, d_b;
   mode_type                     d_mode;
   logic                         d_neg_x, d_neg_t;

   assign {d_px, d_py, d_b, d_mode, d_neg_x, d_neg_t} = side_out;

   polp_back #(
      .COORD_BITS(COORD_BITS),
      .QUO_BITS  (QUO_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (d_valid),
      .in_ready        (d_ready),
      .quo_x           (d_quo_x),
      .quo_t           (d_quo_t),
      .over_x          (d_over_x),
      .over_t          (d_over_t),
      .neg_x           (d_neg_x),
      .neg_t           (d_neg_t),
      .px              (d_px),
      .py              (d_py),
      .b               (d_b),
      .mode            (d_mode),
      .out_valid       (rsp_out.valid),
      .out_ready       (rsp_out.ready),
      .foot_x          (rsp_out.foot_x),
      .foot_y          (rsp_out.foot_y),
      .position_on_line(rsp_out.position_on_line),
      .saturated       (rsp_out.saturated)
   );

endmodule

[bench/point_onto_line_projector_unit_tb.sv]
// testbench for the point onto line projector: directed and random points checked against a predictor
module point_onto_line_projector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import polp_pkg::*;

   localparam int CB = 32;
   localparam int FB = 16;
   localparam kind_type KIND_VERTICAL = 2'd2;
   localparam kind_type KIND_UNUSED   = 2'd3;
   localparam csr_index_type REG_NONE = 2'd3;
   localparam int LATENCY = CB + 10;
   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

   typedef struct packed {
      logic signed [CB-1:0] fx;
      logic signed [CB-1:0] fy;
      logic signed [CB-1:0] pos;
      logic                 sat;
   } foot_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   csr_index_type csr_index = REG_GRADIENT;
   logic [CB-1:0] csr_wdata = '0;

   polp_req_if #(.COORD_BITS(CB)) req();
   polp_rsp_if #(.COORD_BITS(CB)) rsp();

   point_onto_line_projector_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset), .req_in(req.sink), .rsp_out(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   logic signed [CB-1:0] line_m = '0;
   logic signed [CB-1:0] line_b = '0;
   kind_type line_k = KIND_HORIZONTAL;
   foot_t pending_feet[$];
   int mismatches = 0;
   bit sink_stall_long = 0;

   initial begin
      req.valid = 0;
      req.point_x = '0;
      req.point_y = '0;
      rsp.ready = 0;
   end

   // rounded signed division, ties away from zero, quotient magnitude capped at 2^62
   function automatic logic signed [127:0] round_quot(logic signed [255:0] num,
                                                       logic [255:0] den);
      logic [255:0] nm, q, r;
      logic neg;
      neg = num < 0;
      nm = neg ? -num : num;
      q = nm / den;
      r = nm % den;
      if (2 * r >= den) q = q + 1;
      if (q > (256'd1 << 62)) q = 256'd1 << 62;
      return neg ? -$signed({1'b0, q[126:0]}) : $signed({1'b0, q[126:0]});
   endfunction

   function automatic logic signed [127:0] clamp_coord(logic signed [127:0] v,
                                                        inout logic sat);
      if (v > CMAX) begin
         sat = 1;
         return CMAX;
      end
      if (v < CMIN) begin
         sat = 1;
         return CMIN;
      end
      return v;
   endfunction

   function automatic foot_t project_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py);
      logic signed [255:0] s, d, nx, nt, den;
      logic signed [127:0] fx, fy;
      logic sat;
      foot_t f;
      sat = 0;
      if (line_k[1]) begin
         fx = line_b;
         fy = py;
      end else if (line_k == KIND_HORIZONTAL || line_m == 0) begin
         fx = px;
         fy = line_b;
      end else begin
         s = 256'sd1 << FB;
         d = 256'(py) - 256'(line_b);
         den = s * s + 256'(line_m) * 256'(line_m);
         nx = (256'(px) * s + 256'(line_m) * d) <<< FB;
         nt = (256'(line_m) * 256'(px) - d * s) <<< FB;
         fx = round_quot(nx, den);
         fy = 128'(py) + round_quot(nt, den);
      end
      fx = clamp_coord(fx, sat);
      fy = clamp_coord(fy, sat);
      f.fx = fx[CB-1:0];
      f.fy = fy[CB-1:0];
      f.pos = line_k[1] ? fy[CB-1:0] : fx[CB-1:0];
      f.sat = sat;
      return f;
   endfunction

   task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // sink side: random stalls, checks each transfer
   initial begin
      int g;
      foot_t want;
      @(posedge clock iff !reset);
      forever begin
         g = sink_stall_long ? gap_len() : 0;
         rsp.ready <= (g == 0);
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (pending_feet.size() == 0) begin
               report_mismatch("unexpected transfer", rsp.foot_x, '0);
            end else begin
               want = pending_feet.pop_front();
               if (rsp.foot_x !== want.fx) report_mismatch("foot_x", rsp.foot_x, want.fx);
               if (rsp.foot_y !== want.fy) report_mismatch("foot_y", rsp.foot_y, want.fy);
               if (rsp.position_on_line !== want.pos)
                  report_mismatch("position", rsp.position_on_line, want.pos);
               if (rsp.saturated !== want.sat)
                  report_mismatch("saturated", CB'(rsp.saturated), CB'(want.sat));
            end
         end
         if (g > 1) begin
            rsp.ready <= 0;
            repeat (g - 1) @(posedge clock);
         end
      end
   end

   task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py, bit idle);
      int g;
      g = idle ? gap_len() : 0;
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1;
      req.point_x <= px;
      req.point_y <= py;
      pending_feet.push_back(project_point(px, py));
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (pending_feet.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CB-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_GRADIENT:  line_m = val;
         REG_INTERCEPT: line_b = val;
         REG_KIND:      line_k = val[1:0];
         default: ;
      endcase
   endtask

   task automatic set_line(kind_type k, logic [CB-1:0] m, logic [CB-1:0] b);
      write_reg(REG_GRADIENT, m);
      write_reg(REG_INTERCEPT, b);
      write_reg(REG_KIND, {{(CB-2){1'b0}}, k});
   endtask

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return CMAX;
         1: return CMIN;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : -$urandom_range(0, 1 << 20);
         3: return $signed(16'($urandom)) <<< FB;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_reset_line();
      send_point(32'sh0003_8000, -32'sh0001_0000, 0);
      send_point(CMAX, CMIN, 0);
      drain();
   endtask

   task automatic test_directed_lines();
      set_line(KIND_GENERAL, 32'sh0001_0000, 32'sh0002_0000);
      send_point(32'sh0004_0000, 32'sh0000_0000, 0);
      send_point(CMAX, CMAX, 0);
      send_point(CMIN, CMAX, 0);
      send_point(32'sh0000_0001, 32'sh0000_0002, 0);
      drain();
      set_line(KIND_GENERAL, CMAX, CMIN);
      send_point(CMIN, CMAX, 0);
      send_point(CMAX, CMIN, 0);
      send_point('0, '0, 0);
      drain();
      set_line(KIND_GENERAL, CMIN, CMAX);
      send_point(CMAX, CMAX, 0);
      send_point(-32'sd1, -32'sd1, 0);
      drain();
      // zero gradient on a general line acts horizontal
      set_line(KIND_GENERAL, '0, 32'sh0005_0000);
      send_point(32'sh0001_0000, 32'sh0009_0000, 0);
      drain();
      set_line(KIND_VERTICAL, 32'sh0001_0000, CMIN);
      send_point(CMAX, 32'sh1234_5678, 0);
      drain();
      // unused kind decodes as vertical; unknown index is ignored
      set_line(KIND_UNUSED, 32'sh0003_0000, CMAX);
      write_reg(REG_NONE, 32'hdead_beef);
      send_point(CMIN, CMIN, 0);
      drain();
      set_line(KIND_HORIZONTAL, 32'sh0002_0000, -32'sd1);
      send_point(CMIN, CMAX, 0);
      drain();
   endtask

   task automatic test_random_lines();
      kind_type k;
      logic [CB-1:0] m;
      for (int phase = 0; phase < 27; phase++) begin
         k = (phase % 4 == 3) ? kind_type'($urandom_range(1, 3)) : KIND_GENERAL;
         case ($urandom_range(0, 3))
            0: m = $signed(4'($urandom)) <<< FB;
            1: m = $urandom_range(0, 1 << 18) - (1 << 17);
            2: m = (phase % 2) ? CMAX : CMIN;
            default: m = $urandom;
         endcase
         set_line(k, m, rand_coord());
         sink_stall_long = (phase % 5) != 0;
         for (int i = 0; i < 50; i++)
            send_point(rand_coord(), rand_coord(), phase % 5 != 1);
         drain();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_line();
      test_directed_lines();
      test_random_lines();
      while (pending_feet.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

[filelist.f]
src/polp_pkg.sv
src/polp_if.sv
src/polp_front.sv
src/polp_div.sv
src/polp_back.sv
src/point_onto_line_projector_unit.sv
bench/point_onto_line_projector_unit_tb.sv
